// ===== rtl/spcr_pkg.sv =====
// Shared types and constants of the sphere pair collision response block.
`timescale 1ns / 1ps
`default_nettype none
package spcr_pkg;

  localparam logic [2:0] REG_CONTACT_SCALE = 3'd0;
  localparam logic [2:0] REG_VELOCITY_GAIN = 3'd1;
  localparam logic [2:0] REG_RESTITUTION   = 3'd2;
  localparam logic [2:0] REG_HIT_STOP_SPD  = 3'd3;
  localparam logic [2:0] REG_HIT_STOP_FRM  = 3'd4;

  localparam logic [18:0] RST_CONTACT_SCALE = 19'd78643;
  localparam logic [18:0] RST_VELOCITY_GAIN = 19'd78643;
  localparam logic [16:0] RST_RESTITUTION   = 17'd65536;
  localparam logic [30:0] RST_HIT_STOP_SPD  = 31'd26214;
  localparam logic [7:0]  RST_HIT_STOP_FRM  = 8'd15;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [18:0] scale;
    logic [18:0] gain;
    logic [16:0] rest;
    logic [30:0] hss;
    logic [7:0]  frames;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0] disp;
    logic [30:0]      ra;
    logic [30:0]      rb;
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic             player;
  } in_t;

  typedef struct packed {
    logic [2:0][31:0] disp;
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic [63:0]      dist2;
    logic             contact;
    logic             resolve;
    logic [7:0]       hsc;
  } q_t;

  typedef struct packed {
    logic             contact;
    logic [2:0][31:0] nva;
    logic [2:0][31:0] nvb;
    logic [7:0]       hsc;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/spcr_front.sv =====
// Front end: contact and hit-stop classification of each sphere pair.
`timescale 1ns / 1ps
`default_nettype none
module spcr_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spcr_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  spcr_pkg::in_t in_word,
  output logic          q_push,
  output spcr_pkg::q_t  q_word,
  input  logic          q_full
);

  logic fe;
  logic f1_v_r, f2_v_r, f3_v_r;
  spcr_pkg::in_t f1_w_r, f2_w_r, f3_w_r;

  logic signed [63:0] sqd_c [3];
  logic signed [63:0] sqv_c [3];
  logic [63:0] sqd_r [3];
  logic [63:0] sqv_r [3];
  logic [31:0] rsum_r;
  logic [61:0] hs2_r, hs2b_r, hs2c_r;

  logic [63:0] dist2_r, dist2b_r, vsq_r, vsqb_r;
  logic [50:0] tprod;
  logic [50:0] thr_nxt, thr_r;

  logic        big_r;
  logic [63:0] thr2_r;
  logic        contact, hit;

  assign fe       = !f3_v_r || !q_full;
  assign in_ready = fe;
  assign q_push   = f3_v_r && !q_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqd_c[i] = $signed(in_word.disp[i]) * $signed(in_word.disp[i]);
      sqv_c[i] = $signed(in_word.va[i]) * $signed(in_word.va[i]);
    end
  end

  assign tprod   = 51'(rsum_r) * 51'(cfg.scale);
  assign thr_nxt = f1_w_r.player ? (tprod >> FRAC_BITS) : 51'(rsum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (fe) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      f1_w_r <= in_word;
      for (int i = 0; i < 3; i++) begin
        sqd_r[i] <= sqd_c[i];
        sqv_r[i] <= sqv_c[i];
      end
      rsum_r <= {1'b0, in_word.ra} + {1'b0, in_word.rb};
      hs2_r  <= cfg.hss * cfg.hss;

      f2_w_r   <= f1_w_r;
      dist2_r  <= sqd_r[0] + sqd_r[1] + sqd_r[2];
      vsq_r    <= sqv_r[0] + sqv_r[1] + sqv_r[2];
      thr_r    <= thr_nxt;
      hs2b_r   <= hs2_r;

      f3_w_r   <= f2_w_r;
      dist2b_r <= dist2_r;
      vsqb_r   <= vsq_r;
      big_r    <= |thr_r[50:32];
      thr2_r   <= thr_r[31:0] * thr_r[31:0];
      hs2c_r   <= hs2b_r;
    end
  end

  assign contact = big_r || (dist2b_r <= thr2_r);
  assign hit     = contact && f3_w_r.player && (vsqb_r > {2'b00, hs2c_r});

  always_comb begin
    q_word.disp    = f3_w_r.disp;
    q_word.va      = f3_w_r.va;
    q_word.vb      = f3_w_r.vb;
    q_word.dist2   = dist2b_r;
    q_word.contact = contact;
    q_word.resolve = contact && (dist2b_r != 64'd0);
    q_word.hsc     = hit ? cfg.frames : 8'd0;
  end

endmodule
`default_nettype wire

// ===== rtl/spcr_queue.sv =====
// Short queue of classified words between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module spcr_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  spcr_pkg::q_t wdata,
  output logic         full,
  input  logic         pop,
  output spcr_pkg::q_t rdata,
  output logic         valid
);

  spcr_pkg::q_t mem_r [spcr_pkg::QDEPTH];
  logic [spcr_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [spcr_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == (spcr_pkg::QAW+1)'(spcr_pkg::QDEPTH));
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (spcr_pkg::QAW+1)'(spcr_pkg::QDEPTH))
    else $error("queue count beyond depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("count missed a push");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("count missed a pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/spcr_back.sv =====
// Back end: normal, restitution exchange, gain and saturation of velocities.
`timescale 1ns / 1ps
`default_nettype none
module spcr_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  spcr_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  spcr_pkg::q_t   q_word,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output spcr_pkg::res_t out_word
);

  localparam int F   = FRAC_BITS;
  localparam int SQ  = 32;
  localparam int DQ  = F + 1;
  localparam int NW  = F + 2;
  localparam int PR  = NW + 33;
  localparam int PW  = NW + 35;
  localparam int SW  = PW - F;
  localparam int EW  = ((F > 17) ? F : 17) + 1;
  localparam int SDW = SW + EW + 1;
  localparam int DW  = SDW - (F + 1);
  localparam int DLW = NW + DW;
  localparam int DEW = DLW - F;
  localparam int AW  = DEW + 1;
  localparam int GW  = AW + 20;
  localparam int OW  = GW - F;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic             contact;
    logic             resolve;
    logic [7:0]       hsc;
  } ctx_t;

  function automatic sq_t sq_step(input sq_t a);
    logic [34:0] r2;
    logic [34:0] tr;
    sq_t o;
    r2 = {a.rem, a.rad[63:62]};
    tr = {1'b0, a.root, 2'b01};
    if (r2 >= tr) begin
      o.rem  = 33'(r2 - tr);
      o.root = {a.root[30:0], 1'b1};
    end else begin
      o.rem  = r2[32:0];
      o.root = {a.root[30:0], 1'b0};
    end
    o.rad = {a.rad[61:0], 2'b00};
    return o;
  endfunction

  function automatic logic [32+DQ-1:0] div_step(input logic [31:0] rem,
                                                input logic [DQ-1:0] q,
                                                input logic [31:0] len,
                                                input logic b);
    logic [32:0] r2;
    logic [31:0] nrem;
    logic [DQ-1:0] nq;
    r2 = {rem, b};
    if (r2 >= {1'b0, len}) begin
      nrem = 32'(r2 - {1'b0, len});
      nq   = {q[DQ-2:0], 1'b1};
    end else begin
      nrem = r2[31:0];
      nq   = {q[DQ-2:0], 1'b0};
    end
    return {nrem, nq};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [OW-1:0] x);
    logic [OW-32:0] hi;
    hi = x[OW-1:31];
    if ((&hi) || !(|hi)) begin
      return x[31:0];
    end
    return x[OW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  logic be;
  logic out_valid_r;
  spcr_pkg::res_t out_word_r;

  sq_t  sq_init;
  sq_t  sq_r  [SQ];
  ctx_t sqc_r [SQ];
  logic [2:0][31:0] sqd_r [SQ];
  logic [SQ-1:0] sqv_r;

  logic [31:0]   mag_c [3];
  logic [31:0]   drem_r [DQ][3];
  logic [DQ-1:0] dq_r   [DQ][3];
  logic [31:0]   dlen_r [DQ];
  logic [2:0]    dsg_r  [DQ];
  ctx_t          dc_r   [DQ];
  logic [DQ-1:0] dvv_r;

  logic signed [NW-1:0]  n0_r [3];
  logic signed [NW-1:0]  n1_r [3];
  logic signed [NW-1:0]  n2_r [3];
  logic signed [NW-1:0]  n3_r [3];
  logic signed [32:0]    dv0_r [3];
  logic signed [PR-1:0]  pr1_r [3];
  logic signed [PW-1:0]  psum;
  logic signed [SW-1:0]  s2_r;
  logic [EW-1:0]         ef;
  logic signed [EW:0]    ef_s;
  logic signed [SDW-1:0] sd3_r;
  logic signed [DW-1:0]  d4_c;
  logic signed [DLW-1:0] dl4_r [3];
  logic signed [DEW-1:0] dsh_c [3];
  logic signed [AW-1:0]  vae_c [3];
  logic signed [AW-1:0]  vbe_c [3];
  logic signed [AW-1:0]  a5_r [3];
  logic signed [AW-1:0]  b5_r [3];
  logic signed [19:0]    gain_s;
  logic signed [GW-1:0]  ag6_r [3];
  logic signed [GW-1:0]  bg6_r [3];
  logic signed [OW-1:0]  ash_c [3];
  logic signed [OW-1:0]  bsh_c [3];
  ctx_t                  mc_r [7];
  logic [6:0]            mv_r;
  spcr_pkg::res_t        out_nxt;

  assign be        = !out_valid_r || out_ready;
  assign q_pop     = be && q_valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign sq_init = '{rem: '0, root: '0, rad: q_word.dist2};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = sqd_r[SQ-1][i][31] ? 32'(-sqd_r[SQ-1][i]) : sqd_r[SQ-1][i];
    end
  end

  assign ef     = (EW'(1) << F) + EW'(cfg.rest);
  assign ef_s   = {1'b0, ef};
  assign gain_s = {1'b0, cfg.gain};
  assign psum   = PW'(pr1_r[0]) + PW'(pr1_r[1]) + PW'(pr1_r[2]);
  assign d4_c   = DW'(sd3_r >>> (F + 1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsh_c[i] = DEW'(dl4_r[i] >>> F);
      vae_c[i] = $signed(mc_r[4].va[i]);
      vbe_c[i] = $signed(mc_r[4].vb[i]);
      ash_c[i] = OW'(ag6_r[i] >>> F);
      bsh_c[i] = OW'(bg6_r[i] >>> F);
    end
  end

  always_comb begin
    out_nxt.contact = mc_r[6].contact;
    out_nxt.hsc     = mc_r[6].hsc;
    for (int i = 0; i < 3; i++) begin
      out_nxt.nva[i] = mc_r[6].resolve ? sat32(ash_c[i]) : mc_r[6].va[i];
      out_nxt.nvb[i] = mc_r[6].resolve ? sat32(bsh_c[i]) : mc_r[6].vb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r       <= '0;
      dvv_r       <= '0;
      mv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (be) begin
      sqv_r       <= {sqv_r[SQ-2:0], q_valid};
      dvv_r       <= {dvv_r[DQ-2:0], sqv_r[SQ-1]};
      mv_r        <= {mv_r[5:0], dvv_r[DQ-1]};
      out_valid_r <= mv_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      sq_r[0]  <= sq_step(sq_init);
      sqd_r[0] <= q_word.disp;
      sqc_r[0] <= '{va: q_word.va, vb: q_word.vb, contact: q_word.contact,
                    resolve: q_word.resolve, hsc: q_word.hsc};
      for (int k = 1; k < SQ; k++) begin
        sq_r[k]  <= sq_step(sq_r[k-1]);
        sqd_r[k] <= sqd_r[k-1];
        sqc_r[k] <= sqc_r[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        {drem_r[0][i], dq_r[0][i]} <= div_step({1'b0, mag_c[i][31:1]}, '0,
                                               sq_r[SQ-1].root, mag_c[i][0]);
        dsg_r[0][i] <= sqd_r[SQ-1][i][31];
      end
      dlen_r[0] <= sq_r[SQ-1].root;
      dc_r[0]   <= sqc_r[SQ-1];
      for (int k = 1; k < DQ; k++) begin
        for (int i = 0; i < 3; i++) begin
          {drem_r[k][i], dq_r[k][i]} <= div_step(drem_r[k-1][i], dq_r[k-1][i],
                                                 dlen_r[k-1], 1'b0);
        end
        dsg_r[k]  <= dsg_r[k-1];
        dlen_r[k] <= dlen_r[k-1];
        dc_r[k]   <= dc_r[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        n0_r[i]  <= dsg_r[DQ-1][i] ? -$signed({1'b0, dq_r[DQ-1][i]})
                                   : $signed({1'b0, dq_r[DQ-1][i]});
        dv0_r[i] <= $signed({dc_r[DQ-1].vb[i][31], dc_r[DQ-1].vb[i]})
                  - $signed({dc_r[DQ-1].va[i][31], dc_r[DQ-1].va[i]});
        n1_r[i]  <= n0_r[i];
        pr1_r[i] <= n0_r[i] * dv0_r[i];
        n2_r[i]  <= n1_r[i];
        n3_r[i]  <= n2_r[i];
        dl4_r[i] <= n3_r[i] * d4_c;
        a5_r[i]  <= vae_c[i] + AW'(dsh_c[i]);
        b5_r[i]  <= vbe_c[i] - AW'(dsh_c[i]);
        ag6_r[i] <= a5_r[i] * gain_s;
        bg6_r[i] <= b5_r[i] * gain_s;
      end
      s2_r  <= SW'(psum >>> F);
      sd3_r <= s2_r * ef_s;

      mc_r[0] <= dc_r[DQ-1];
      for (int k = 1; k < 7; k++) begin
        mc_r[k] <= mc_r[k-1];
      end
      out_word_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sphere_pair_collision_response_top.sv =====
// Top level of the sphere pair collision response block.
//
// One sphere pair enters on the in_ channel (valid/ready) and one result
// word leaves on the out_ channel for every pair, in order. The front end
// squares the displacement and velocity, forms the contact threshold and
// classifies contact and hit stop in three stages, then drops the word into
// a four-entry queue. The back end takes the square root in 32 one-bit
// stages, forms the normal in FRAC_BITS+1 stages of three parallel dividers,
// then runs seven arithmetic stages and an output register.
// The default FRAC_BITS of 16 gives Q16.16; throughput is one pair per
// cycle while out_ready stays high.
// When out_ready is low the back end holds in place, the queue fills and
// in_ready falls once the front end cannot place its word; the held result
// stays on the out_ ports. Synchronous reset empties all stages and the
// queue and loads the registers with their defaults. Configuration is
// written through cfg_we/cfg_index/cfg_wdata while the block is drained.
`timescale 1ns / 1ps
`default_nettype none
module sphere_pair_collision_response_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_disp_x,
  input  logic [31:0] in_disp_y,
  input  logic [31:0] in_disp_z,
  input  logic [30:0] in_radius_a,
  input  logic [30:0] in_radius_b,
  input  logic [31:0] in_vel_a_x,
  input  logic [31:0] in_vel_a_y,
  input  logic [31:0] in_vel_a_z,
  input  logic [31:0] in_vel_b_x,
  input  logic [31:0] in_vel_b_y,
  input  logic [31:0] in_vel_b_z,
  input  logic        in_player_pair,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_contact,
  output logic [31:0] out_new_vel_a_x,
  output logic [31:0] out_new_vel_a_y,
  output logic [31:0] out_new_vel_a_z,
  output logic [31:0] out_new_vel_b_x,
  output logic [31:0] out_new_vel_b_y,
  output logic [31:0] out_new_vel_b_z,
  output logic [7:0]  out_hit_stop_count,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  spcr_pkg::cfg_t cfg_r;
  spcr_pkg::in_t  in_word;
  spcr_pkg::q_t   fq_word, bq_word;
  spcr_pkg::res_t res;
  logic q_push, q_full, q_pop, q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale  <= spcr_pkg::RST_CONTACT_SCALE;
      cfg_r.gain   <= spcr_pkg::RST_VELOCITY_GAIN;
      cfg_r.rest   <= spcr_pkg::RST_RESTITUTION;
      cfg_r.hss    <= spcr_pkg::RST_HIT_STOP_SPD;
      cfg_r.frames <= spcr_pkg::RST_HIT_STOP_FRM;
    end else if (cfg_we) begin
      case (cfg_index)
        spcr_pkg::REG_CONTACT_SCALE: cfg_r.scale  <= cfg_wdata[18:0];
        spcr_pkg::REG_VELOCITY_GAIN: cfg_r.gain   <= cfg_wdata[18:0];
        spcr_pkg::REG_RESTITUTION:   cfg_r.rest   <= cfg_wdata[16:0];
        spcr_pkg::REG_HIT_STOP_SPD:  cfg_r.hss    <= cfg_wdata[30:0];
        spcr_pkg::REG_HIT_STOP_FRM:  cfg_r.frames <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_word.disp   = {in_disp_z, in_disp_y, in_disp_x};
  assign in_word.ra     = in_radius_a;
  assign in_word.rb     = in_radius_b;
  assign in_word.va     = {in_vel_a_z, in_vel_a_y, in_vel_a_x};
  assign in_word.vb     = {in_vel_b_z, in_vel_b_y, in_vel_b_x};
  assign in_word.player = in_player_pair;

  spcr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_push   (q_push),
    .q_word   (fq_word),
    .q_full   (q_full)
  );

  spcr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (fq_word),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (bq_word),
    .valid (q_valid)
  );

  spcr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_word    (bq_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (res)
  );

  assign out_contact        = res.contact;
  assign out_new_vel_a_x    = res.nva[0];
  assign out_new_vel_a_y    = res.nva[1];
  assign out_new_vel_a_z    = res.nva[2];
  assign out_new_vel_b_x    = res.nvb[0];
  assign out_new_vel_b_y    = res.nvb[1];
  assign out_new_vel_b_z    = res.nvb[2];
  assign out_hit_stop_count = res.hsc;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the sphere pair collision response block: random and directed pairs, scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int FB = 16;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [31:0] d [3];
    logic [30:0] ra, rb;
    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic pl;
  } pair_t;

  typedef struct {
    logic c;
    logic [31:0] a [3];
    logic [31:0] b [3];
    logic [7:0] h;
  } resp_t;

  class response_board;
    resp_t pending [$];
    int errors = 0;
    logic [18:0] scale = spcr_pkg::RST_CONTACT_SCALE;
    logic [18:0] gain = spcr_pkg::RST_VELOCITY_GAIN;
    logic [16:0] rest = spcr_pkg::RST_RESTITUTION;
    logic [30:0] hss = spcr_pkg::RST_HIT_STOP_SPD;
    logic [7:0] frames = spcr_pkg::RST_HIT_STOP_FRM;

    function void write_reg(logic [2:0] idx, logic [30:0] v);
      case (idx)
        spcr_pkg::REG_CONTACT_SCALE: scale = v[18:0];
        spcr_pkg::REG_VELOCITY_GAIN: gain = v[18:0];
        spcr_pkg::REG_RESTITUTION: rest = v[16:0];
        spcr_pkg::REG_HIT_STOP_SPD: hss = v;
        spcr_pkg::REG_HIT_STOP_FRM: frames = v[7:0];
        default: ;
      endcase
    endfunction

    function logic signed [127:0] fshr(logic signed [127:0] x, int s);
      return x >>> s;
    endfunction

    function logic [31:0] sat(logic signed [127:0] x);
      if (x > 128'sd2147483647) return 32'h7fffffff;
      if (x < -128'sd2147483648) return 32'h80000000;
      return x[31:0];
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r, bt;
      r = 64'd0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= r + bt) begin
          v -= r + bt;
          r = (r >> 1) + bt;
        end else begin
          r >>= 1;
        end
        bt >>= 2;
      end
      return r;
    endfunction

    function void note_pair(pair_t p);
      resp_t e;
      logic [127:0] thr, dist2, va2;
      logic signed [127:0] len, n [3], s, dd, dl, acc;
      thr = 128'(p.ra) + 128'(p.rb);
      if (p.pl) thr = (thr * 128'(scale)) >> FB;
      dist2 = 0;
      va2 = 0;
      for (int i = 0; i < 3; i++) begin
        dist2 += 128'($signed(p.d[i]) * $signed(p.d[i]));
        va2 += 128'($signed(p.va[i]) * $signed(p.va[i]));
      end
      e.c = (thr >= (128'd1 << 32)) || (dist2 <= thr * thr);
      e.h = (e.c && p.pl && va2 > 128'(hss) * 128'(hss)) ? frames : 8'd0;
      for (int i = 0; i < 3; i++) begin
        e.a[i] = p.va[i];
        e.b[i] = p.vb[i];
      end
      if (e.c && dist2 != 0) begin
        len = 128'(isqrt(dist2[63:0]));
        acc = 0;
        for (int i = 0; i < 3; i++) begin
          n[i] = (128'(signed'(p.d[i])) <<< FB) / len;
          acc += n[i] * (128'(signed'(p.vb[i])) - 128'(signed'(p.va[i])));
        end
        s = fshr(acc, FB);
        dd = fshr(s * ((128'sd1 <<< FB) + 128'(rest)), FB + 1);
        for (int i = 0; i < 3; i++) begin
          dl = fshr(n[i] * dd, FB);
          e.a[i] = sat(fshr((128'(signed'(p.va[i])) + dl) * 128'(gain), FB));
          e.b[i] = sat(fshr((128'(signed'(p.vb[i])) - dl) * 128'(gain), FB));
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(resp_t r);
      resp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.c !== e.c) begin
        $display("%0t: contact exp %0h got %0h", $time, e.c, r.c);
        errors++;
      end
      if (r.h !== e.h) begin
        $display("%0t: hit stop exp %0d got %0d", $time, e.h, r.h);
        errors++;
      end
      for (int i = 0; i < 3; i++) begin
        if (r.a[i] !== e.a[i]) begin
          $display("%0t: vel a[%0d] exp %h got %h", $time, i, e.a[i], r.a[i]);
          errors++;
        end
        if (r.b[i] !== e.b[i]) begin
          $display("%0t: vel b[%0d] exp %h got %h", $time, i, e.b[i], r.b[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, in_player_pair = 0;
  logic [31:0] in_disp_x = 0, in_disp_y = 0, in_disp_z = 0;
  logic [30:0] in_radius_a = 0, in_radius_b = 0;
  logic [31:0] in_vel_a_x = 0, in_vel_a_y = 0, in_vel_a_z = 0;
  logic [31:0] in_vel_b_x = 0, in_vel_b_y = 0, in_vel_b_z = 0;
  logic out_contact;
  logic [31:0] out_new_vel_a_x, out_new_vel_a_y, out_new_vel_a_z;
  logic [31:0] out_new_vel_b_x, out_new_vel_b_y, out_new_vel_b_z;
  logic [7:0] out_hit_stop_count;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [30:0] cfg_wdata = 0;

  response_board board = new();
  int cycles = 0, sent = 0, got = 0, contacts = 0;
  bit long_hold = 0, hold_done = 0;

  always #6 clk = ~clk;

  sphere_pair_collision_response_top i_dut (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    resp_t r;
    if (rst_n && out_valid && out_ready) begin
      r.c = out_contact;
      r.a[0] = out_new_vel_a_x; r.a[1] = out_new_vel_a_y; r.a[2] = out_new_vel_a_z;
      r.b[0] = out_new_vel_b_x; r.b[1] = out_new_vel_b_y; r.b[2] = out_new_vel_b_z;
      r.h = out_hit_stop_count;
      got++;
      if (r.c) contacts++;
      board.check_result(r);
    end
  end

  // receiver: stall pattern, with one long hold-off
  initial begin
    int mode;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_done = 1;
      end
      mode = (cycles / 500) % 3;
      out_ready <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(3) != 0)
                                                    : ($urandom_range(1) == 1);
    end
  end

  function automatic logic [31:0] rnd_disp(logic [30:0] rs);
    case ($urandom_range(5))
      0: return $urandom;
      1: return 0;
      default: return $urandom_range(rs < 31'd2 ? 1 : rs) * ($urandom_range(1) ? 1 : -1);
    endcase
  endfunction

  function automatic logic [31:0] rnd_vel();
    case ($urandom_range(4))
      0: return $urandom;
      1: return {$urandom_range(1) ? 32'h7fffffff : 32'h80000000};
      default: return $signed($urandom_range(32'h3ffff)) - 32'sh1ffff;
    endcase
  endfunction

  task automatic send_pair(pair_t p);
    in_valid <= 1;
    in_disp_x <= p.d[0]; in_disp_y <= p.d[1]; in_disp_z <= p.d[2];
    in_radius_a <= p.ra; in_radius_b <= p.rb;
    in_vel_a_x <= p.va[0]; in_vel_a_y <= p.va[1]; in_vel_a_z <= p.va[2];
    in_vel_b_x <= p.vb[0]; in_vel_b_y <= p.vb[1]; in_vel_b_z <= p.vb[2];
    in_player_pair <= p.pl;
    do @(posedge clk); while (!in_ready);
    board.note_pair(p);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.write_reg(idx, v);
  endtask

  function automatic pair_t rnd_pair(bit shaped);
    pair_t p;
    logic [30:0] rs;
    if (shaped) begin
      p.ra = 31'($urandom_range(32'h40000)); p.rb = 31'($urandom_range(32'h40000));
    end else begin
      p.ra = 31'($urandom); p.rb = 31'($urandom);
    end
    rs = p.ra + p.rb;
    for (int i = 0; i < 3; i++) begin
      p.d[i] = shaped ? rnd_disp(rs / 2) : $urandom;
      p.va[i] = rnd_vel();
      p.vb[i] = rnd_vel();
    end
    p.pl = 1'($urandom_range(1));
    return p;
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      if ($urandom_range(3) == 0) idle_gap($urandom_range(1, 8));
      repeat (burst) begin
        send_pair(rnd_pair($urandom_range(9) != 0));
        n--;
      end
    end
  endtask

  initial begin
    pair_t p;
    logic [31:0] ext [6];
    ext = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h00010000};
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    for (int k = 0; k < 24; k++) begin
      p = rnd_pair(1);
      case (k % 6)
        0: for (int i = 0; i < 3; i++) p.d[i] = 0;
        1: begin
          p.ra = 31'h7fffffff; p.rb = 31'h7fffffff;
          for (int i = 0; i < 3; i++) p.d[i] = ext[(k + i) % 6];
        end
        2: begin p.ra = 0; p.rb = 0; end
        3: for (int i = 0; i < 3; i++) begin
          p.va[i] = ext[(k + i) % 6]; p.vb[i] = ext[(k + i + 2) % 6];
        end
        default: p.d[k % 3] = 32'(p.ra) + 32'(p.rb);
      endcase
      p.pl = k[1];
      send_pair(p);
    end
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(spcr_pkg::REG_CONTACT_SCALE, 31'd0);
          write_reg(spcr_pkg::REG_VELOCITY_GAIN, 31'd0);
          write_reg(spcr_pkg::REG_RESTITUTION, 31'd0);
          write_reg(spcr_pkg::REG_HIT_STOP_SPD, 31'd0);
          write_reg(spcr_pkg::REG_HIT_STOP_FRM, 31'd0);
        end
        1: begin
          write_reg(spcr_pkg::REG_CONTACT_SCALE, 31'd262144);
          write_reg(spcr_pkg::REG_VELOCITY_GAIN, 31'd262144);
          write_reg(spcr_pkg::REG_RESTITUTION, 31'd65536);
          write_reg(spcr_pkg::REG_HIT_STOP_SPD, 31'h7fffffff);
          write_reg(spcr_pkg::REG_HIT_STOP_FRM, 31'd255);
        end
        default: begin
          write_reg(spcr_pkg::REG_CONTACT_SCALE, 31'($urandom_range(262144)));
          write_reg(spcr_pkg::REG_VELOCITY_GAIN, 31'($urandom_range(262144)));
          write_reg(spcr_pkg::REG_RESTITUTION, 31'($urandom_range(65536)));
          write_reg(spcr_pkg::REG_HIT_STOP_SPD, 31'($urandom_range(32'h30000)));
          write_reg(spcr_pkg::REG_HIT_STOP_FRM, 31'($urandom_range(255)));
          write_reg(REG_UNUSED, 31'($urandom));
        end
      endcase
      if (ph == 2) long_hold = 1;
      random_phase(300);
      drain();
    end
    $display("pairs sent %0d, results %0d, contacts %0d, six register settings", sent, got,
             contacts);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sphere_pair_collision_response_top.f =====
rtl/spcr_pkg.sv
rtl/spcr_front.sv
rtl/spcr_queue.sv
rtl/spcr_back.sv
rtl/sphere_pair_collision_response_top.sv
tb/sv/tb_top.sv
